[rtl/masked_frame_photon_counter_unit_defines.svh]
// Assertion macros used by the photon counter top level.
`ifndef MASKED_FRAME_PHOTON_COUNTER_UNIT_DEFINES_SVH
`define MASKED_FRAME_PHOTON_COUNTER_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define MFPC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition never holds.
`define MFPC_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[rtl/mfpc_pkg.sv]
// Types, constants and codes of the masked frame photon counter.
package mfpc_pkg;

   localparam int NUM_PIXELS    = 65536;
   localparam int NUM_DETECTORS = 4;
   localparam int PIX_W         = $clog2(NUM_PIXELS);
   localparam int DET_W         = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;

   localparam int COUNT_W  = 16;
   localparam int TOTAL_W  = 32;
   localparam int SUM_W    = 48;
   localparam int FRAMES_W = 32;
   localparam int MEAN_W   = 40;
   localparam int FRAC_W   = 8;
   localparam int DVD_W    = SUM_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [1:0] {
      CMD_MASK_WRITE = 2'd0,
      CMD_PHOTON     = 2'd1,
      CMD_END_FRAME  = 2'd2,
      CMD_REPORT     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EOF    = 2'd1,
      OP_REPORT = 2'd2
   } op_type;

   typedef enum logic {
      KIND_FRAME_TOTAL = 1'b0,
      KIND_MEAN        = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LOAD,
      B_DIV,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      op_type             op;
      logic [COUNT_W-1:0] value;
      logic [1:0]         det;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[rtl/mfpc_front.sv]
// Front end: accepts transactions, owns the mask memory, classifies work.
module mfpc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mfpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [mfpc_pkg::REQ_USER_W-1:0]     req_tuser,
   input  mfpc_pkg::q_status_type              q_status,
   output mfpc_pkg::q_push_type                q_push
);
   import mfpc_pkg::*;

   logic [1:0]       mask_mem [NUM_PIXELS];
   logic [1:0]       mask_rd_ff;

   logic             s1_valid_ff, s1_valid_in;
   cmd_type          s1_cmd_ff;
   logic [COUNT_W-1:0] s1_count_ff;
   logic [1:0]       s1_det_ff;
   logic             s1_apply_ff;
   logic             s1_pix_ok_ff;

   cmd_type          in_cmd;
   logic [15:0]      in_pixel;
   logic [1:0]       in_mask;
   logic [COUNT_W-1:0] in_count;
   logic [1:0]       in_det;
   logic             in_apply;
   logic             in_pix_ok;
   logic [PIX_W-1:0] in_addr;
   logic             accept;
   logic             needs_push;
   logic             s1_done;
   logic             counts;

   // Unpack the request fields
   assign in_pixel  = req_tdata[15:0];
   assign in_mask   = req_tdata[17:16];
   assign in_count  = req_tdata[33:18];
   assign in_det    = req_tdata[35:34];
   assign in_cmd    = cmd_type'(req_tuser[1:0]);
   assign in_apply  = req_tuser[2];
   assign in_pix_ok = 32'(in_pixel) < NUM_PIXELS;
   assign in_addr   = PIX_W'(in_pixel);
   assign accept    = req_tvalid && req_tready;

   // Write masks on accept; read the entry for every accepted transaction
   always_ff @(posedge clock) begin
      if (accept && in_cmd == CMD_MASK_WRITE && in_pix_ok) begin
         mask_mem[in_addr] <= in_mask;
      end
      if (accept) begin
         mask_rd_ff <= mask_mem[in_addr];
      end
   end

   // Decide what the held transaction hands to the back end
   always_comb begin
      counts     = !s1_apply_ff || (s1_pix_ok_ff && mask_rd_ff == 2'd0);
      needs_push = 1'b0;
      q_push     = '0;
      case (s1_cmd_ff)
         CMD_PHOTON: begin
            needs_push = counts;
            q_push.entry.op = OP_ADD;
         end
         CMD_END_FRAME: begin
            needs_push = 1'b1;
            q_push.entry.op = OP_EOF;
         end
         CMD_REPORT: begin
            needs_push = 1'b1;
            q_push.entry.op = OP_REPORT;
         end
         default: begin
            needs_push = 1'b0;
            q_push.entry.op = OP_ADD;
         end
      endcase
      q_push.entry.value = s1_count_ff;
      q_push.entry.det   = s1_det_ff;
      q_push.valid       = s1_valid_ff && needs_push && !q_status.full;
   end

   assign s1_done     = s1_valid_ff && (!needs_push || !q_status.full);
   assign req_tready  = !s1_valid_ff || s1_done;
   assign s1_valid_in = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);

   // Hold the classified transaction until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff    <= in_cmd;
         s1_count_ff  <= in_count;
         s1_det_ff    <= in_det;
         s1_apply_ff  <= in_apply;
         s1_pix_ok_ff <= in_pix_ok;
      end
   end

endmodule

[rtl/mfpc_queue.sv]
// Short work queue between the front end and the back end.
module mfpc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  mfpc_pkg::q_push_type       q_push,
   input  logic                       q_pop,
   output mfpc_pkg::q_status_type     q_status,
   output mfpc_pkg::q_entry_type      q_head
);
   import mfpc_pkg::*;

   q_entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign q_head         = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.valid && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push.valid && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

[rtl/mfpc_back.sv]
// Back end: frame accumulation, detector statistics, mean division, result register.
module mfpc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  mfpc_pkg::q_status_type            q_status,
   input  mfpc_pkg::q_entry_type             q_head,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mfpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import mfpc_pkg::*;

   back_state_type        state_ff, state_in;

   logic [TOTAL_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]      sum_ff [NUM_DETECTORS];
   logic [FRAMES_W-1:0]   frames_ff [NUM_DETECTORS];
   logic [DET_W-1:0]      idx_ff, idx_in;
   logic [DVD_W-1:0]      dvd_ff, dvd_in;
   logic [FRAMES_W:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;

   logic                  out_valid_ff, out_valid_in;
   kind_type              out_kind_ff, out_kind_in;
   logic [TOTAL_W-1:0]    out_total_ff, out_total_in;
   logic [1:0]            out_det_ff, out_det_in;
   logic [MEAN_W-1:0]     out_mean_ff, out_mean_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;
   logic                  out_load;
   logic                  stat_wr;
   logic [DET_W-1:0]      rd_idx;
   logic [SUM_W-1:0]      rd_sum;
   logic [FRAMES_W-1:0]   rd_frames;
   logic [TOTAL_W:0]      acc_sum;
   logic [SUM_W:0]        det_sum;
   logic [SUM_W-1:0]      sum_new;
   logic [FRAMES_W-1:0]   frames_new;
   logic [FRAMES_W:0]     rem_shift;
   logic                  q_bit;
   logic                  det_ok;
   logic                  idx_last;
   logic                  div_last;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign rd_idx    = (state_ff == B_IDLE) ? DET_W'(q_head.det) : idx_ff;
   assign rd_sum    = sum_ff[rd_idx];
   assign rd_frames = frames_ff[rd_idx];
   assign det_ok    = 32'(q_head.det) < NUM_DETECTORS;
   assign idx_last  = idx_ff == DET_W'(NUM_DETECTORS - 1);
   assign div_last  = cnt_ff == DIV_CNT_W'(DVD_W - 1);

   // Saturating adders for the frame total and the detector sum
   assign acc_sum    = {1'b0, acc_ff} + (TOTAL_W + 1)'(q_head.value);
   assign det_sum    = {1'b0, rd_sum} + (SUM_W + 1)'(acc_ff);
   assign sum_new    = det_sum[SUM_W] ? '1 : det_sum[SUM_W-1:0];
   assign frames_new = (&rd_frames) ? rd_frames : rd_frames + 1'b1;

   // One restoring division step
   assign rem_shift = {rem_ff[FRAMES_W-1:0], dvd_ff[DVD_W-1]};
   assign q_bit     = rem_shift >= {1'b0, rd_frames};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty && q_head.op == OP_REPORT) begin
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            state_in = B_DIV;
         end
         B_DIV: begin
            if (div_last) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               state_in = idx_last ? B_IDLE : B_LOAD;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Datapath and handshake outputs
   always_comb begin
      q_pop        = 1'b0;
      out_load     = 1'b0;
      stat_wr      = 1'b0;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      out_kind_in  = out_kind_ff;
      out_total_in = out_total_ff;
      out_det_in   = out_det_ff;
      out_mean_in  = out_mean_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               case (q_head.op)
                  OP_ADD: begin
                     q_pop  = 1'b1;
                     acc_in = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
                  end
                  OP_EOF: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        out_load     = 1'b1;
                        stat_wr      = det_ok;
                        acc_in       = '0;
                        out_kind_in  = KIND_FRAME_TOTAL;
                        out_total_in = acc_ff;
                        out_det_in   = q_head.det;
                        out_mean_in  = '0;
                        out_last_in  = 1'b1;
                     end
                  end
                  OP_REPORT: begin
                     q_pop  = 1'b1;
                     idx_in = '0;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         B_LOAD: begin
            dvd_in = {rd_sum, FRAC_W'(0)};
            rem_in = '0;
            cnt_in = '0;
         end
         B_DIV: begin
            rem_in = q_bit ? rem_shift - {1'b0, rd_frames} : rem_shift;
            dvd_in = {dvd_ff[DVD_W-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
         end
         B_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_kind_in  = KIND_MEAN;
               out_total_in = '0;
               out_det_in   = 2'(idx_ff);
               out_mean_in  = (rd_frames == '0) ? '0 : dvd_ff[MEAN_W-1:0];
               out_last_in  = idx_last;
               idx_in       = idx_ff + 1'b1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
      out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // Control state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int d = 0; d < NUM_DETECTORS; d++) begin
            sum_ff[d]    <= '0;
            frames_ff[d] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
         if (stat_wr) begin
            sum_ff[rd_idx]    <= sum_new;
            frames_ff[rd_idx] <= frames_new;
         end
      end
   end

   // Divider and result payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      out_kind_ff  <= out_kind_in;
      out_total_ff <= out_total_in;
      out_det_ff   <= out_det_in;
      out_mean_ff  <= out_mean_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - TOTAL_W - 2 - MEAN_W)'(0), out_mean_ff, out_det_ff,
                        out_total_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/masked_frame_photon_counter_unit.sv]
// Masked frame photon counter: per-frame photon totals and per-detector Q8 means.
//
// Request channel (req_*): one transaction per command. Mask writes store a
// 2-bit code per pixel; photon events add their count to the running frame
// total when the mask allows; end of frame emits one result; a report emits
// one mean result per detector, the last one flagged by rsp_tlast.
// Throughput: mask writes and photon events are taken one per cycle while
// the queue has room. An end of frame result passes the front-end register,
// the queue and the result register on its way to rsp_tvalid. Each report
// mean comes from a 56-step bit-serial divider, one quotient bit per cycle.
// The mask memory is written and read once per cycle on the request side.
// A four-entry queue parts the request side from the statistics side, so
// requests keep flowing while a report divides or a result waits.
// When the receiver holds rsp_tready low, the result register holds and the
// queue fills; req_tready falls whenever a command must push into a full queue.
// Reset clears the frame total, detector statistics, queue and result
// register. Mask contents are undefined until written.
`include "masked_frame_photon_counter_unit_defines.svh"

module masked_frame_photon_counter_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: pixel[15:0], mask_value[17:16], photon_count[33:18], detector[35:34]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mfpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: cmd[1:0], apply_mask[2]
   input  logic [mfpc_pkg::REQ_USER_W-1:0]   req_tuser,
   // rsp_tdata: frame_total[31:0], detector_index[33:32], mean_q8[73:34]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mfpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: result_kind[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import mfpc_pkg::*;

   q_push_type   q_push;
   q_status_type q_status;
   q_entry_type  q_head;
   logic         q_pop;

   mfpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push)
   );

   mfpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   mfpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Queue never overflows or underflows; frame totals are single, mean-free results
   `MFPC_ASSERT_NEVER(a_no_push_full, clock, reset, q_push.valid && q_status.full,
                      "push to full queue")
   `MFPC_ASSERT_NEVER(a_no_pop_empty, clock, reset, q_pop && q_status.empty,
                      "pop from empty queue")
   `MFPC_ASSERT_IMPLIES(a_total_shape, clock, reset, rsp_tvalid && !rsp_tuser,
                        rsp_tlast && rsp_tdata[73:34] == '0, "bad frame total result")

endmodule

[bench/tb.sv]
// Self-checking testbench for the masked frame photon counter unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfpc_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 310;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 300;

   typedef struct {
      cmd_type     cmd;
      logic [15:0] pixel;
      logic [1:0]  mask_value;
      logic [15:0] photon_count;
      logic        apply_mask;
      logic [1:0]  detector;
   } command_type;

   typedef struct {
      command_type c;
      bit          typed;
      logic [31:0] typed_total;
   } step_row_type;

   typedef struct {
      kind_type    kind;
      logic [31:0] total;
      logic [1:0]  det;
      logic [39:0] mean;
      logic        last;
   } result_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_THREE_OF_FOUR,
      READY_SPARSE
   } stall_mode_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // Predictor state: mask contents, running frame total, detector statistics
   logic [1:0]  mask_mem [0:NUM_PIXELS-1];
   bit          mask_written [0:NUM_PIXELS-1];
   int          written_pixels [$];
   logic [31:0] frame_acc;
   logic [47:0] det_sum [0:NUM_DETECTORS-1];
   logic [31:0] det_frames [0:NUM_DETECTORS-1];

   result_type  pending_results [$];
   result_type  want;
   int          errors      = 0;
   int          cycle_count = 0;
   int          burst_left  = 0;

   bit             hold_armed = 1'b0;
   int             hold_left  = 0;
   int             mode_left  = 0;
   int             phase      = 0;
   stall_mode_type ready_mode = READY_ALWAYS;

   masked_frame_photon_counter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Advance the predictor by one accepted command; queue its results if asked
   task automatic count_command(input command_type c, input bit emit);
      logic [32:0] acc_next;
      logic [48:0] sum_next;
      logic [63:0] dividend;
      logic [63:0] quotient;
      result_type  r;
      case (c.cmd)
         CMD_MASK_WRITE: begin
            mask_mem[c.pixel] = c.mask_value;
            if (!mask_written[c.pixel]) begin
               mask_written[c.pixel] = 1'b1;
               written_pixels.push_back(c.pixel);
            end
         end
         CMD_PHOTON: begin
            // a pixel counts when unmasked or when its mask code is zero
            if (!c.apply_mask || mask_mem[c.pixel] == 2'd0) begin
               acc_next  = {1'b0, frame_acc} + c.photon_count;
               frame_acc = acc_next[32] ? '1 : acc_next[31:0];
            end
         end
         CMD_END_FRAME: begin
            sum_next = {1'b0, det_sum[c.detector]} + frame_acc;
            det_sum[c.detector] = sum_next[48] ? '1 : sum_next[47:0];
            if (det_frames[c.detector] != '1)
               det_frames[c.detector] = det_frames[c.detector] + 1;
            r = '{KIND_FRAME_TOTAL, frame_acc, c.detector, 40'd0, 1'b1};
            if (emit)
               pending_results.push_back(r);
            frame_acc = '0;
         end
         CMD_REPORT: begin
            for (int d = 0; d < NUM_DETECTORS; d++) begin
               quotient = '0;
               if (det_frames[d] != 0) begin
                  dividend = {8'd0, det_sum[d], 8'd0};
                  quotient = dividend / {32'd0, det_frames[d]};
               end
               r = '{KIND_MEAN, 32'd0, d[1:0], quotient[39:0], d == NUM_DETECTORS - 1};
               if (emit)
                  pending_results.push_back(r);
            end
         end
      endcase
   endtask

   // Offer one command, idling between bursts, and hold it until accepted
   task automatic offer_command(input command_type c, input bit emit);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, c.detector, c.photon_count, c.mask_value, c.pixel};
      req_tuser  <= {c.apply_mask, c.cmd};
      do
         @(posedge clock);
      while (!req_tready);
      count_command(c, emit);
   endtask

   function automatic logic [15:0] pick_written();
      return 16'(written_pixels[$urandom_range(0, written_pixels.size() - 1)]);
   endfunction

   function automatic logic [15:0] random_count();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return 16'd0;
      if (sel == 1)
         return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // Receiver: stall patterns in random stretches, plus one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 80);
         end
         mode_left = mode_left - 1;
         phase     = phase + 1;
         case (ready_mode)
            READY_ALWAYS:        rsp_tready <= 1'b1;
            READY_COIN:          rsp_tready <= 1'($urandom_range(0, 1));
            READY_THREE_OF_FOUR: rsp_tready <= (phase % 4) != 0;
            READY_SPARSE:        rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result with no expectation pending: tdata %0h", rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.total) begin
               $error("frame_total: expected %0h, got %0h", want.total, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[33:32] !== want.det) begin
               $error("detector_index: expected %0d, got %0d", want.det, rsp_tdata[33:32]);
               errors++;
            end
            if (rsp_tdata[73:34] !== want.mean) begin
               $error("mean_q8: expected %0h, got %0h", want.mean, rsp_tdata[73:34]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("masked_frame_photon_counter_unit test failed");
         $finish;
      end
   end

   initial begin
      step_row_type rows [20];
      command_type  c;
      int           sent;
      int           n;
      int           pick;

      frame_acc = '0;
      for (int d = 0; d < NUM_DETECTORS; d++) begin
         det_sum[d]    = '0;
         det_frames[d] = '0;
      end

      // Directed rows: typed totals where they follow at a glance
      rows = '{
         '{'{CMD_REPORT,     16'h0000, 2'd0, 16'h0000, 1'b0, 2'd0}, 1'b1, 32'd0},
         '{'{CMD_END_FRAME,  16'h0000, 2'd0, 16'h0000, 1'b0, 2'd0}, 1'b1, 32'd0},
         '{'{CMD_MASK_WRITE, 16'h0000, 2'd0, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_MASK_WRITE, 16'hFFFF, 2'd3, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_MASK_WRITE, 16'h5555, 2'd1, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_MASK_WRITE, 16'hAAAA, 2'd2, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'h0000, 2'd0, 16'hFFFF, 1'b1, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'hFFFF, 2'd0, 16'hFFFF, 1'b1, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'h5555, 2'd0, 16'd100,  1'b1, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'hAAAA, 2'd0, 16'd7,    1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'h1234, 2'd0, 16'd0,    1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_END_FRAME,  16'h0000, 2'd0, 16'h0000, 1'b0, 2'd3}, 1'b1, 32'd65542},
         '{'{CMD_PHOTON,     16'h0000, 2'd0, 16'd1,    1'b1, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_END_FRAME,  16'h0000, 2'd0, 16'h0000, 1'b0, 2'd3}, 1'b1, 32'd1},
         '{'{CMD_MASK_WRITE, 16'h0000, 2'd1, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'h0000, 2'd0, 16'd5,    1'b1, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_PHOTON,     16'hFFFF, 2'd0, 16'd9,    1'b0, 2'd0}, 1'b0, 32'd0},
         '{'{CMD_END_FRAME,  16'h0000, 2'd0, 16'h0000, 1'b0, 2'd1}, 1'b1, 32'd9},
         '{'{CMD_END_FRAME,  16'h0000, 2'd0, 16'h0000, 1'b0, 2'd2}, 1'b1, 32'd0},
         '{'{CMD_REPORT,     16'h0000, 2'd0, 16'h0000, 1'b0, 2'd0}, 1'b0, 32'd0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (rows[i]) begin
         if (rows[i].typed) begin
            if (rows[i].c.cmd == CMD_END_FRAME)
               pending_results.push_back('{KIND_FRAME_TOTAL, rows[i].typed_total,
                                           rows[i].c.detector, 40'd0, 1'b1});
            else
               for (int d = 0; d < NUM_DETECTORS; d++)
                  pending_results.push_back('{KIND_MEAN, 32'd0, d[1:0], 40'd0,
                                              d == NUM_DETECTORS - 1});
         end
         offer_command(rows[i].c, !rows[i].typed);
      end

      // Close the current frame and report once more
      offer_command('{CMD_END_FRAME, 16'd0, 2'd0, 16'd0, 1'b0, 2'd0}, 1'b1);
      offer_command('{CMD_REPORT, 16'd0, 2'd0, 16'd0, 1'b0, 2'd0}, 1'b1);

      // Random frames, reports and noise; the receiver holds off once early on
      hold_armed = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            offer_command('{CMD_REPORT, 16'($urandom_range(0, 65535)), 2'd0, 16'd0,
                            1'b0, 2'd0}, 1'b1);
            sent++;
         end else if (pick < 16) begin
            c.cmd          = cmd_type'($urandom_range(0, 3));
            c.pixel        = 16'($urandom_range(0, 65535));
            c.mask_value   = 2'($urandom_range(0, 3));
            c.photon_count = 16'($urandom_range(0, 65535));
            c.apply_mask   = 1'($urandom_range(0, 1));
            c.detector     = 2'($urandom_range(0, 3));
            // never read a mask entry that was not written
            if (c.cmd == CMD_PHOTON && c.apply_mask && !mask_written[c.pixel])
               c.pixel = pick_written();
            offer_command(c, 1'b1);
            sent++;
         end else begin
            n = $urandom_range(0, 10);
            for (int k = 0; k < n; k++) begin
               c.detector     = 2'($urandom_range(0, 3));
               c.photon_count = random_count();
               if ($urandom_range(0, 4) == 0) begin
                  c.cmd        = CMD_MASK_WRITE;
                  c.pixel      = $urandom_range(0, 1) ? pick_written()
                                                      : 16'($urandom_range(0, 65535));
                  c.mask_value = 2'($urandom_range(0, 3));
                  c.apply_mask = 1'($urandom_range(0, 1));
               end else begin
                  c.cmd        = CMD_PHOTON;
                  c.mask_value = 2'($urandom_range(0, 3));
                  c.apply_mask = 1'($urandom_range(0, 1));
                  c.pixel      = c.apply_mask ? pick_written()
                                              : 16'($urandom_range(0, 65535));
               end
               offer_command(c, 1'b1);
               sent++;
            end
            offer_command('{CMD_END_FRAME, 16'($urandom_range(0, 65535)),
                            2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))}, 1'b1);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then watch for stray results
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("masked_frame_photon_counter_unit test passed");
      else
         $display("masked_frame_photon_counter_unit test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/mfpc_pkg.sv
rtl/mfpc_front.sv
rtl/mfpc_queue.sv
rtl/mfpc_back.sv
rtl/masked_frame_photon_counter_unit.sv
bench/tb.sv
